FILE: design/natlog_pkg.sv
// ----------------------------------------------------------------------------
// natlog_pkg: shared constants for the double-precision natural log pipeline
// Q52 fixed-point constants, field positions and the series length default.
// ----------------------------------------------------------------------------
`default_nettype none

package natlog_pkg;

    // Fixed-point format and double layout
    localparam int FRAC_BITS = 52;
    localparam int EXP_BITS  = 11;
    localparam int EXP_BIAS  = 1023;

    // ln 2 in Q52, rounded to nearest
    localparam logic [51:0] LN2_Q52 = 52'hB17217F7D1CF8;

    // Default number of series terms
    localparam int SERIES_TERMS_DEF = 31;

    // Count trailing zero bits of a small positive constant
    function automatic int ctz(input int v);
        int n;
        n = 0;
        for (int i = 0; i < 6; i++) begin
            if (v != 0 && ((v >> n) & 1) == 0) begin
                n = n + 1;
            end
        end
        return n;
    endfunction

endpackage

`default_nettype wire

FILE: design/natural_log_of_double_unit.sv
// ----------------------------------------------------------------------------
// natural_log_of_double_unit: ln|x| of a double bit pattern in Q52
// Pipelined series evaluation: (exp - 1023) * ln2 + sum of truncated terms.
// ----------------------------------------------------------------------------
// Accepts one item per clock while the output is not stalled and returns one
// result per item, in order. The pipeline is an input stage, then one
// two-stage round per series term (a split 53x53 product for the next power
// of (1 - f) alongside a split reciprocal product that divides the previous
// term by k * 2^k), and one closing round for the last term. The whole
// pipeline advances whenever the output register is empty or being taken,
// so a stalled result holds every stage and nothing is lost or repeated.
// The sign bit is ignored; zero, subnormal, infinity and NaN patterns go
// through the same formula.
`default_nettype none

module natural_log_of_double_unit #(
    parameter int SERIES_TERMS = natlog_pkg::SERIES_TERMS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [63:0]        s_float_bits,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [63:0]      m_log_value
);

    localparam int FB = natlog_pkg::FRAC_BITS;
    localparam int T  = SERIES_TERMS;

    logic adv;

    // Stage-boundary registers between rounds (index 0 is the input stage)
    logic        valid_b_reg [0:T];
    logic [52:0] p_b_reg     [0:T];
    logic [52:0] q_b_reg     [0:T-1];
    logic [63:0] acc_b_reg   [0:T];

    logic        m_valid_reg;
    logic [63:0] m_log_value_reg;

    // Advance every stage when the output slot is free or being emptied
    assign adv         = !m_valid_reg || m_ready;
    assign s_ready     = adv;
    assign m_valid     = m_valid_reg;
    assign m_log_value = signed'(m_log_value_reg);

    // Input stage: split the pattern, form 1 - f and the exponent term
    logic [10:0]        biased;
    logic signed [11:0] unb_exp;
    logic signed [64:0] exp_prod;
    logic [52:0]        q_next;

    always_comb begin
        biased   = s_float_bits[62:52];
        unb_exp  = signed'({1'b0, biased}) - 12'sd1023;
        exp_prod = unb_exp * signed'({13'd0, natlog_pkg::LN2_Q52});
        q_next   = (53'd1 << FB) - {1'b0, s_float_bits[51:0]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_b_reg[0] <= 1'b0;
        end else if (adv) begin
            valid_b_reg[0] <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p_b_reg[0]   <= 53'd1 << FB;
            q_b_reg[0]   <= q_next;
            acc_b_reg[0] <= exp_prod[63:0];
        end
    end

    // One round per term: power product and division of the previous term
    genvar g;
    generate
        for (g = 1; g <= T + 1; g++) begin : gen_round
            localparam int K = g - 1;

            logic        va_reg;
            logic [63:0] acc_a_reg;
            logic [63:0] acc_next;

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    va_reg <= 1'b0;
                end else if (adv) begin
                    va_reg <= valid_b_reg[g-1];
                end
            end

            always_ff @(posedge aclk) begin
                if (adv) begin
                    acc_a_reg <= acc_b_reg[g-1];
                end
            end

            // Next power (1 - f)^g, split into four partial products
            if (g <= T) begin : gen_pow
                logic [51:0] pp11_reg;
                logic [52:0] pp10_reg;
                logic [52:0] pp01_reg;
                logic [53:0] pp00_reg;
                logic [105:0] psum;

                always_ff @(posedge aclk) begin
                    if (adv) begin
                        pp11_reg <= p_b_reg[g-1][52:27] * q_b_reg[g-1][52:27];
                        pp10_reg <= p_b_reg[g-1][52:27] * q_b_reg[g-1][26:0];
                        pp01_reg <= p_b_reg[g-1][26:0]  * q_b_reg[g-1][52:27];
                        pp00_reg <= p_b_reg[g-1][26:0]  * q_b_reg[g-1][26:0];
                    end
                end

                always_comb begin
                    psum = ({54'd0, pp11_reg} << 54) + ({53'd0, pp10_reg} << 27)
                         + ({53'd0, pp01_reg} << 27) + {52'd0, pp00_reg};
                end

                always_ff @(posedge aclk) begin
                    if (adv) begin
                        p_b_reg[g] <= psum[104:52];
                    end
                end

                // Carry 1 - f on to the rounds that still need it
                if (g < T) begin : gen_qpass
                    logic [52:0] q_a_reg;

                    always_ff @(posedge aclk) begin
                        if (adv) begin
                            q_a_reg <= q_b_reg[g-1];
                        end
                    end

                    always_ff @(posedge aclk) begin
                        if (adv) begin
                            q_b_reg[g] <= q_a_reg;
                        end
                    end
                end
            end

            // Term K: floor((1 - p_K) / (K * 2^K)) via shift and reciprocal
            if (g >= 2) begin : gen_div
                localparam int E  = natlog_pkg::ctz(K);
                localparam int O  = K >> E;
                localparam int SH = K + E;
                localparam int L  = $clog2(O);
                localparam int S  = FB + L;
                localparam logic [63:0] MUL_C = ((64'd1 << S) + 64'(O) - 64'd1) / 64'(O);

                logic [52:0]  diff;
                logic [51:0]  x;
                logic [52:0]  d11_reg;
                logic [51:0]  d10_reg;
                logic [52:0]  d01_reg;
                logic [51:0]  d00_reg;
                logic [104:0] dsum;
                logic [104:0] quo;

                always_comb begin
                    diff = (53'd1 << FB) - p_b_reg[g-1];
                    x    = 52'(diff >> SH);
                end

                always_ff @(posedge aclk) begin
                    if (adv) begin
                        d11_reg <= x[51:26] * MUL_C[52:26];
                        d10_reg <= x[51:26] * MUL_C[25:0];
                        d01_reg <= x[25:0]  * MUL_C[52:26];
                        d00_reg <= x[25:0]  * MUL_C[25:0];
                    end
                end

                always_comb begin
                    dsum = ({52'd0, d11_reg} << 52) + ({53'd0, d10_reg} << 26)
                         + ({52'd0, d01_reg} << 26) + {53'd0, d00_reg};
                    quo  = dsum >> S;
                    acc_next = acc_a_reg + quo[63:0];
                end
            end else begin : gen_nodiv
                assign acc_next = acc_a_reg;
            end

            // Close the round: into the next boundary or the output register
            if (g <= T) begin : gen_mid
                always_ff @(posedge aclk) begin
                    if (!aresetn) begin
                        valid_b_reg[g] <= 1'b0;
                    end else if (adv) begin
                        valid_b_reg[g] <= va_reg;
                    end
                end

                always_ff @(posedge aclk) begin
                    if (adv) begin
                        acc_b_reg[g] <= acc_next;
                    end
                end
            end else begin : gen_out
                always_ff @(posedge aclk) begin
                    if (!aresetn) begin
                        m_valid_reg <= 1'b0;
                    end else if (adv) begin
                        m_valid_reg <= va_reg;
                    end
                end

                always_ff @(posedge aclk) begin
                    if (adv) begin
                        m_log_value_reg <= acc_next;
                    end
                end
            end
        end
    endgenerate

endmodule

`default_nettype wire
